@@ design/tss_pkg.sv @@
// Shared constants and tables for the tilt servo stabiliser.
`timescale 1ns / 1ps
package tss_pkg;

    localparam int CW      = 36;   // CORDIC x/y datapath width
    localparam int ZW      = 27;   // CORDIC angle accumulator, degrees Q16
    localparam int CNT_W   = 5;    // CORDIC step counter
    localparam int TAB_LEN = 24;

    localparam logic signed [ZW-1:0] ATAN_TAB [TAB_LEN] = '{
        27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
        27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
        27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
        27'sd917,     27'sd458,     27'sd229,    27'sd115,
        27'sd57,      27'sd29,      27'sd14,     27'sd7,
        27'sd4,       27'sd2,       27'sd1,      27'sd0
    };
    localparam logic signed [ZW-1:0] Z_HALF_TURN = 27'sd11796480;

    localparam int          REM_W    = 17;
    localparam logic [REM_W:0] DIVISOR = 18'd131000;
    localparam logic [16:0] INV_GAIN = 17'd39797;
    localparam logic [16:0] YAW_BIAS = 17'd65500;

    localparam int          DT_W   = 26;
    localparam logic [31:0] DT_CAP = 32'd33554432;

    localparam int          CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_HOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MOT_HOLD = 3'd3;

endpackage

@@ design/tss_cordic.sv @@
// Iterative CORDIC vectoring unit: one rotation per cycle.
`timescale 1ns / 1ps
module tss_cordic import tss_pkg::*; #(
    parameter int STEPS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    output logic                 o_done,
    output logic signed [ZW-1:0] o_z,
    output logic signed [CW-1:0] o_mag
);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

    logic signed [CW-1:0] r_x, r_y, xs, ys;
    logic signed [ZW-1:0] r_z;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy, r_done, r_zero;

    assign xs = r_x >>> r_cnt;
    assign ys = r_y >>> r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_zero <= (i_x == '0) && (i_y == '0);
                if (i_x < 0) begin
                    // fold the left half-plane over
                    r_x <= -i_x;
                    r_y <= -i_y;
                    r_z <= (i_y >= 0) ? Z_HALF_TURN : -Z_HALF_TURN;
                end else begin
                    r_x <= i_x;
                    r_y <= i_y;
                    r_z <= '0;
                end
            end else if (r_busy) begin
                if (r_y > 0) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + ATAN_TAB[r_cnt];
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - ATAN_TAB[r_cnt];
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_z    = r_zero ? '0 : r_z;
    assign o_mag  = r_zero ? '0 : r_x;

    ap_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("cordic done while busy");
    ap_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy) else $error("cordic start did not take");
    ap_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt <= LAST) else $error("cordic step count overran");

endmodule

@@ design/tss_div.sv @@
// Bit-serial restoring divider by the constant yaw scale.
`timescale 1ns / 1ps
module tss_div import tss_pkg::*; #(
    parameter int DW = 51
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    output logic          o_busy,
    output logic [DW-1:0] o_quot
);
    localparam int CW_D = $clog2(DW + 1);

    logic [REM_W-1:0] r_rem;
    logic [DW-1:0]    r_q;
    logic [CW_D-1:0]  r_cnt;
    logic             r_busy;
    logic [REM_W:0]   trial;
    logic             ge;

    assign trial = {r_rem, r_q[DW-1]};
    assign ge    = trial >= DIVISOR;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_q    <= i_dividend;
        end else if (r_busy) begin
            // shift one dividend bit in, one quotient bit out
            r_rem <= ge ? REM_W'(trial - DIVISOR) : trial[REM_W-1:0];
            r_q   <= {r_q[DW-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW_D'(DW - 1)) r_busy <= 1'b0;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

    ap_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> {1'b0, r_rem} < DIVISOR) else $error("remainder out of range");
    ap_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy && r_cnt == '0) else $error("divider start lost");
    ap_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cnt == CW_D'(DW - 1) && !i_start |=> !r_busy)
        else $error("divider ran past its last bit");

endmodule

@@ design/tilt_servo_stabilizer_top.sv @@
// Top level of the tilt servo stabiliser: sequencer, yaw integrator, servo logic.
`timescale 1ns / 1ps
// One word in gives one word out. An accepted word passes through the roll
// and pitch CORDIC runs, which overlap with the bit-serial divider that
// scales the gyro rate, one quotient bit a cycle; the next word is taken only
// once all of them are done and the result is in the output register. A
// finished word waits in the output register while the next input word is
// already taken.
module tilt_servo_stabilizer_top import tss_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int CORDIC_STEPS    = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [15:0]          i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // timestamp_ms, accel_x, accel_y, accel_z, gyro_z, pir_level, zero fill
    input  logic [103:0]         s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // servo_roll_a, servo_roll_b, servo_pitch_a, servo_pitch_b, servo_yaw,
    // led_on, zero fill
    output logic [47:0]          m_axis_tdata
);
    localparam int F    = ANGLE_FRAC_BITS;
    localparam int AW   = F + 10;
    localparam int YW   = F + 9;
    localparam int DW   = 43 + F;
    localparam int RSH  = 16 - F;
    localparam logic [ZW-1:0] HALF = (RSH == 0) ? '0 : ZW'(1) << ((RSH == 0) ? 0 : RSH - 1);
    localparam logic signed [YW-1:0] YLIM = YW'(90) <<< F;

    typedef enum logic [2:0] {S_IDLE, S_PREP, S_ROLL, S_MAG, S_PITCH, S_DIVW, S_UPD} t_state;

    t_state r_state;
    logic [6:0]  r_db;
    logic [7:0]  r_center;
    logic [15:0] r_yaw_hold, r_mot_hold;

    logic [31:0]        r_ts, r_last, r_ovr_start, r_yp_start;
    logic signed [15:0] r_ax, r_ay, r_az, r_gz;
    logic               r_pir, r_ovr, r_yp;
    logic signed [YW-1:0] r_yaw;
    logic signed [AW-1:0] r_roll, r_pitch;
    logic [51:0]        r_prod;
    logic [7:0]         r_pos [5];
    logic               r_mvalid;
    logic [47:0]        r_mdata;

    logic                 c_start, c_done;
    logic signed [CW-1:0] c_x, c_y, c_mag;
    logic signed [ZW-1:0] c_z;
    logic                 d_start, d_busy;
    logic [DW-1:0]        d_dividend, d_quot;

    logic [31:0]     dt_raw;
    logic [DT_W-1:0] dt;
    logic [15:0]     gz_abs;
    logic signed [DW+1:0] ysum;
    logic signed [YW-1:0] yaw_sat;

    // update results
    logic [7:0]  n_pos [5];
    logic        n_ovr, n_yp;
    logic [31:0] n_ovr_start, n_yp_start;
    logic [7:0]  cs;
    logic signed [10:0] ro, po;

    function automatic logic signed [AW-1:0] q16_angle(input logic signed [ZW-1:0] z);
        logic [ZW-1:0] mg, rd;
        mg = z[ZW-1] ? ZW'(-z) : ZW'(z);
        rd = (mg + HALF) >> RSH;
        return z[ZW-1] ? -AW'(rd) : AW'(rd);
    endfunction

    function automatic logic [AW-1:0] abs_a(input logic signed [AW-1:0] a);
        return a[AW-1] ? AW'(-a) : AW'(a);
    endfunction

    function automatic logic signed [10:0] map_off(input logic signed [AW-1:0] a);
        logic signed [10:0] d, s, h;
        d = a[AW-1] ? -11'(abs_a(a) >> F) : 11'(abs_a(a) >> F);
        s = d + 11'sd90;
        h = s[10] ? -((-s) >>> 1) : (s >>> 1);
        return h - 11'sd45;
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [10:0] v);
        if (v < 0) return 8'd0;
        if (v > 11'sd180) return 8'd180;
        return v[7:0];
    endfunction

    function automatic logic beyond(input logic signed [AW-1:0] a, input logic [6:0] db);
        return abs_a(a) > (AW'(db) << F);
    endfunction

    tss_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk, .i_rst_n, .i_start(c_start), .i_x(c_x), .i_y(c_y),
        .o_done(c_done), .o_z(c_z), .o_mag(c_mag)
    );

    tss_div #(.DW(DW)) u_div (
        .i_clk, .i_rst_n, .i_start(d_start), .i_dividend(d_dividend),
        .o_busy(d_busy), .o_quot(d_quot)
    );

    assign c_start = (r_state == S_PREP) || (r_state == S_MAG);
    assign c_x = (r_state == S_PREP) ? (CW'(r_az) <<< 16)
                                      : CW'((r_prod + 52'd32768) >> 16);
    assign c_y = (r_state == S_PREP) ? (CW'(r_ay) <<< 16) : -(CW'(r_ax) <<< 16);

    assign dt_raw     = r_ts - r_last;
    assign dt         = (dt_raw > DT_CAP) ? DT_W'(DT_CAP) : dt_raw[DT_W-1:0];
    assign gz_abs     = r_gz[15] ? 16'(-r_gz) : 16'(r_gz);
    assign d_start    = (r_state == S_PREP);
    assign d_dividend = (DW'(gz_abs * dt) << F) + DW'(YAW_BIAS);

    // add the signed increment and saturate
    always_comb begin
        ysum = r_gz[15] ? -$signed({2'b00, d_quot}) : $signed({2'b00, d_quot});
        ysum = ysum + (DW+2)'(r_yaw);
        if (ysum > (DW+2)'(YLIM))       yaw_sat = YLIM;
        else if (ysum < -(DW+2)'(YLIM)) yaw_sat = -YLIM;
        else                            yaw_sat = YW'(ysum);
    end

    always_comb begin
        cs = (r_center > 8'd180) ? 8'd180 : r_center;
        ro = map_off(r_roll);
        po = map_off(r_pitch);
        for (int i = 0; i < 5; i++) n_pos[i] = r_pos[i];
        n_ovr       = r_ovr;
        n_yp        = r_yp;
        n_ovr_start = r_ovr_start;
        n_yp_start  = r_yp_start;
        if (!r_ovr) begin
            if (beyond(r_roll, r_db)) begin
                n_pos[0] = clamp8($signed({3'b000, r_center}) - ro);
                n_pos[1] = clamp8($signed({3'b000, r_center}) + ro);
            end else begin
                n_pos[0] = cs;
                n_pos[1] = cs;
            end
            if (beyond(r_pitch, r_db)) begin
                n_pos[2] = clamp8($signed({3'b000, r_center}) + po);
                n_pos[3] = n_pos[2];
            end else begin
                n_pos[2] = cs;
                n_pos[3] = cs;
            end
            if (!r_yp && beyond(AW'(r_yaw), r_db)) begin
                n_pos[4]   = clamp8($signed({3'b000, r_center}) + map_off(AW'(r_yaw)));
                n_yp       = 1'b1;
                n_yp_start = r_ts;
            end
        end
        if (n_yp && (r_ts - n_yp_start) > {16'd0, r_yaw_hold}) begin
            n_pos[4] = cs;
            n_yp     = 1'b0;
        end
        if (r_pir && !r_ovr) begin
            n_ovr       = 1'b1;
            n_ovr_start = r_ts;
            n_pos[0] = 8'd45;
            n_pos[1] = 8'd135;
            n_pos[2] = 8'd45;
            n_pos[3] = 8'd135;
            n_pos[4] = 8'd60;
        end
        if (n_ovr && (r_ts - n_ovr_start) > {16'd0, r_mot_hold}) begin
            for (int i = 0; i < 5; i++) n_pos[i] = cs;
            n_ovr = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_db        <= 7'd5;
            r_center    <= 8'd90;
            r_yaw_hold  <= 16'd1000;
            r_mot_hold  <= 16'd2000;
            r_yaw       <= '0;
            r_last      <= '0;
            r_ovr       <= 1'b0;
            r_ovr_start <= '0;
            r_yp        <= 1'b0;
            r_yp_start  <= '0;
            for (int i = 0; i < 5; i++) r_pos[i] <= 8'd90;
            r_mvalid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_DEADBAND: r_db       <= i_cfg_wdata[6:0];
                    REG_CENTER:   r_center   <= i_cfg_wdata[7:0];
                    REG_YAW_HOLD: r_yaw_hold <= i_cfg_wdata;
                    REG_MOT_HOLD: r_mot_hold <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready && r_state != S_UPD) r_mvalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_ts    <= s_axis_tdata[31:0];
                        r_ax    <= s_axis_tdata[47:32];
                        r_ay    <= s_axis_tdata[63:48];
                        r_az    <= s_axis_tdata[79:64];
                        r_gz    <= s_axis_tdata[95:80];
                        r_pir   <= s_axis_tdata[96];
                        r_state <= S_PREP;
                    end
                end
                S_PREP: r_state <= S_ROLL;
                S_ROLL: begin
                    if (c_done) begin
                        r_roll  <= q16_angle(c_z);
                        r_prod  <= 52'(c_mag[CW-2:0]) * 52'(INV_GAIN);
                        r_state <= S_MAG;
                    end
                end
                S_MAG: r_state <= S_PITCH;
                S_PITCH: begin
                    if (c_done) begin
                        r_pitch <= q16_angle(c_z);
                        r_state <= S_DIVW;
                    end
                end
                S_DIVW: begin
                    if (!d_busy) begin
                        r_yaw   <= yaw_sat;
                        r_last  <= r_ts;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    // hold until the output register is free
                    if (!r_mvalid || m_axis_tready) begin
                        for (int i = 0; i < 5; i++) r_pos[i] <= n_pos[i];
                        r_ovr       <= n_ovr;
                        r_ovr_start <= n_ovr_start;
                        r_yp        <= n_yp;
                        r_yp_start  <= n_yp_start;
                        r_mdata     <= {7'd0, n_ovr, n_pos[4], n_pos[3], n_pos[2],
                                        n_pos[1], n_pos[0]};
                        r_mvalid    <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

    ap_yaw_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_yaw <= YLIM && r_yaw >= -YLIM) else $error("yaw accumulator beyond limit");
    ap_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[40] == r_ovr) else $error("LED out of step");
    ap_servo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:0] <= 8'd180 && m_axis_tdata[15:8] <= 8'd180
            && m_axis_tdata[23:16] <= 8'd180 && m_axis_tdata[31:24] <= 8'd180
            && m_axis_tdata[39:32] <= 8'd180) else $error("servo angle above 180");

endmodule
